[rtl/ppp_pkg.sv]
// Shared types and constants for the point-to-pixel projection pipeline.
// Used by every module under rtl; depends on nothing.
package ppp_pkg;

	localparam int COORD_W  = 20;          // signed world / camera coordinate
	localparam int ROT_W    = 16;          // signed Q1.14 rotation entry
	localparam int ROT_FRAC = 14;
	localparam int PROD_W   = ROT_W + COORD_W;
	localparam int ACC_W    = PROD_W + 2;  // three products plus shifted translation
	localparam int FC_W     = 20;          // unsigned focal length / principal point
	localparam int EXT_W    = 16;          // image width / height in pixels
	localparam int PIX_W    = 24;          // output pixel coordinate
	localparam int NUM_W    = FC_W + COORD_W + 1;  // signed focal * coordinate
	localparam int DIV_W    = NUM_W - 2;   // magnitude of numerator, fits 39 bits
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 6;

	// Register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_ROT_X   = 3'd0,
		REG_ROT_Y   = 3'd1,
		REG_ROT_Z   = 3'd2,
		REG_TRANS   = 3'd3,
		REG_FC_X    = 3'd4,
		REG_FC_Y    = 3'd5,
		REG_EXTENT  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_u;
		logic [PIX_W-1:0] pixel_v;
		logic             pixel_valid;
	} pixel_t;

	// Rigid transform settings handed to the transform stages
	typedef struct packed {
		logic [3*ROT_W-1:0]   rot_x;
		logic [3*ROT_W-1:0]   rot_y;
		logic [3*ROT_W-1:0]   rot_z;
		logic [3*COORD_W-1:0] trans;
	} xform_cfg_t;

	// Camera-frame point leaving the transform stages
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      zpos;
	} cam_point_t;

endpackage

[rtl/ppp_transform.sv]
// Three-stage rigid transform: multiply, sum with translation, round and saturate.
// Depends on ppp_pkg.
module ppp_transform (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  ppp_pkg::point_t         point,
	input  ppp_pkg::xform_cfg_t     cfg,
	output logic                    out_valid,
	output ppp_pkg::cam_point_t     cam
);
	import ppp_pkg::*;

	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (ROT_FRAC - 1);
	localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam int SH_W = ACC_W - ROT_FRAC;

	logic signed [ROT_W-1:0]   rot [3][3];
	logic signed [COORD_W-1:0] pc [3];
	logic signed [COORD_W-1:0] tr [3];
	logic [3*ROT_W-1:0]        rows [3];

	logic                      v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0]  prod_s1 [3][3];
	logic signed [ACC_W-1:0]   acc_s2 [3];
	logic signed [COORD_W-1:0] crd_s3 [3];

	logic signed [ACC_W-1:0]   sum [3];
	logic signed [SH_W-1:0]    sh [3];
	logic signed [COORD_W-1:0] sat [3];

	// Unpack rotation entries, point and translation
	always_comb begin
		rows[0] = cfg.rot_x;
		rows[1] = cfg.rot_y;
		rows[2] = cfg.rot_z;
		pc[0] = point.point_x;
		pc[1] = point.point_y;
		pc[2] = point.point_z;
		for (int r = 0; r < 3; r++) begin
			tr[r] = cfg.trans[r*COORD_W +: COORD_W];
			for (int c = 0; c < 3; c++) begin
				rot[r][c] = rows[r][c*ROT_W +: ROT_W];
			end
		end
	end

	// Add products, translation and rounding half
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = ACC_W'(prod_s1[r][0]) + ACC_W'(prod_s1[r][1]) + ACC_W'(prod_s1[r][2])
				+ {{(ACC_W-COORD_W-ROT_FRAC){tr[r][COORD_W-1]}}, tr[r], {ROT_FRAC{1'b0}}}
				+ RND;
		end
	end

	// Drop fraction bits (floor) and clamp to coordinate range
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sh[r] = acc_s2[r][ACC_W-1:ROT_FRAC];
			if (sh[r] > SH_W'(CMAX))
				sat[r] = CMAX;
			else if (sh[r] < SH_W'(CMIN))
				sat[r] = CMIN;
			else
				sat[r] = sh[r][COORD_W-1:0];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= rot[r][c] * pc[c];
				end
				acc_s2[r] <= sum[r];
				crd_s3[r] <= sat[r];
			end
		end
	end

	assign out_valid = v_s3;
	assign cam.x     = crd_s3[0];
	assign cam.y     = crd_s3[1];
	assign cam.z     = crd_s3[2];
	assign cam.zpos  = (crd_s3[2] > 0);

endmodule

[rtl/ppp_divider.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// Depends on ppp_pkg.
module ppp_divider #(
	parameter int SIDE_W = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [ppp_pkg::DIV_W-1:0] num_a,
	input  logic [ppp_pkg::DIV_W-1:0] num_b,
	input  logic [ppp_pkg::COORD_W-1:0] den,
	input  logic [SIDE_W-1:0]         side_in,
	output logic                      out_valid,
	output logic [ppp_pkg::DIV_W-1:0] quo_a,
	output logic [ppp_pkg::DIV_W-1:0] quo_b,
	output logic [SIDE_W-1:0]         side_out
);
	import ppp_pkg::*;

	localparam int W = DIV_W;
	localparam int D = COORD_W;

	logic         v_s   [W];
	logic [D-1:0] den_s [W];
	logic [SIDE_W-1:0] side_s [W];
	logic [W-1:0] dvd_s [2][W];
	logic [W-1:0] quo_s [2][W];
	logic [D-1:0] rem_s [2][W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic              pv;
		logic [D-1:0]      pden;
		logic [SIDE_W-1:0] pside;
		logic [W-1:0]      pdvd [2];
		logic [W-1:0]      pquo [2];
		logic [D-1:0]      prem [2];
		logic [D:0]        cand [2];
		logic              ge [2];

		// Pick up previous stage, or the inputs at the head
		if (k == 0) begin : g_head
			assign pv      = in_valid;
			assign pden    = den;
			assign pside   = side_in;
			assign pdvd[0] = num_a;
			assign pdvd[1] = num_b;
			assign pquo[0] = '0;
			assign pquo[1] = '0;
			assign prem[0] = '0;
			assign prem[1] = '0;
		end else begin : g_body
			assign pv      = v_s[k-1];
			assign pden    = den_s[k-1];
			assign pside   = side_s[k-1];
			assign pdvd[0] = dvd_s[0][k-1];
			assign pdvd[1] = dvd_s[1][k-1];
			assign pquo[0] = quo_s[0][k-1];
			assign pquo[1] = quo_s[1][k-1];
			assign prem[0] = rem_s[0][k-1];
			assign prem[1] = rem_s[1][k-1];
		end

		// Shift in next dividend bit and try subtracting
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				cand[l] = {prem[l], pdvd[l][W-1]};
				ge[l]   = (cand[l] >= {1'b0, pden});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]    <= pden;
				side_s[k]   <= pside;
				dvd_s[0][k] <= {pdvd[0][W-2:0], 1'b0};
				dvd_s[1][k] <= {pdvd[1][W-2:0], 1'b0};
				quo_s[0][k] <= {pquo[0][W-2:0], ge[0]};
				quo_s[1][k] <= {pquo[1][W-2:0], ge[1]};
				rem_s[0][k] <= ge[0] ? D'(cand[0] - {1'b0, pden}) : cand[0][D-1:0];
				rem_s[1][k] <= ge[1] ? D'(cand[1] - {1'b0, pden}) : cand[1][D-1:0];
			end
		end
	end

	assign out_valid = v_s[W-1];
	assign quo_a     = quo_s[0][W-1];
	assign quo_b     = quo_s[1][W-1];
	assign side_out  = side_s[W-1];

endmodule

[rtl/point_to_pixel_projection.sv]
// Top level of the pinhole projection pipeline: config port, numerator, limits, output.
// Depends on ppp_pkg, ppp_transform and ppp_divider.
//
// Projects one point per cycle while the skid entry is empty. An accepted point passes 45
// registers before its pixel is offered: three transform stages, one numerator
// multiply, 39 divider stages (one quotient bit each), one offset add and the output
// register. The divider depth sets the latency; throughput is one item per cycle while
// results are taken. A two-entry output stage keeps the input open while one finished
// item waits. Config writes land on APB at byte address 8*index and must occur only
// while the pipeline is empty.
module point_to_pixel_projection #(
	parameter int PIXEL_FRAC_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        point_valid,
	output logic                        point_ready,
	input  ppp_pkg::point_t             point,
	output logic                        result_valid,
	input  logic                        result_ready,
	output ppp_pkg::pixel_t             result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppp_pkg::ADDR_W-1:0]  paddr,
	input  logic [ppp_pkg::DATA_W-1:0]  pwdata,
	output logic [ppp_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import ppp_pkg::*;

	localparam int LIM_W = EXT_W + PIXEL_FRAC_BITS;
	localparam int U_W   = NUM_W;

	logic [3*ROT_W-1:0]   rot_x_q, rot_y_q, rot_z_q;
	logic [3*COORD_W-1:0] trans_q;
	logic [2*FC_W-1:0]    fc_x_q, fc_y_q;
	logic [2*EXT_W-1:0]   extent_q;
	reg_idx_t             reg_idx;
	logic                 wr_en;

	logic                 en;
	xform_cfg_t           xcfg;
	logic                 tv;
	cam_point_t           cam;

	logic                   v_s4;
	logic signed [NUM_W-1:0] num_x_s4, num_y_s4;
	logic [COORD_W-1:0]     den_s4;
	logic                   zpos_s4;

	logic [DIV_W-1:0]       mag_x, mag_y;
	logic                   dv;
	logic [DIV_W-1:0]       qx, qy;
	logic [2:0]             dside;

	logic                   v_s6, zpos_s6;
	logic signed [U_W-1:0]  u_s6, v_coord_s6;

	logic [LIM_W-1:0]       wlim, hlim;
	logic                   in_img;
	pixel_t                 item;
	logic                   push, pop;
	logic                   ov_q, sv_q;
	pixel_t                 out_q, skid_q;

	// Configuration register file
	assign reg_idx = reg_idx_t'(paddr[5:3]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q  <= 48'h0000_0000_4000;
			rot_y_q  <= 48'h0000_4000_0000;
			rot_z_q  <= 48'h4000_0000_0000;
			trans_q  <= '0;
			fc_x_q   <= '0;
			fc_y_q   <= '0;
			extent_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ROT_X:  rot_x_q  <= pwdata[3*ROT_W-1:0];
				REG_ROT_Y:  rot_y_q  <= pwdata[3*ROT_W-1:0];
				REG_ROT_Z:  rot_z_q  <= pwdata[3*ROT_W-1:0];
				REG_TRANS:  trans_q  <= pwdata[3*COORD_W-1:0];
				REG_FC_X:   fc_x_q   <= pwdata[2*FC_W-1:0];
				REG_FC_Y:   fc_y_q   <= pwdata[2*FC_W-1:0];
				REG_EXTENT: extent_q <= pwdata[2*EXT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_ROT_X:  prdata = DATA_W'(rot_x_q);
			REG_ROT_Y:  prdata = DATA_W'(rot_y_q);
			REG_ROT_Z:  prdata = DATA_W'(rot_z_q);
			REG_TRANS:  prdata = DATA_W'(trans_q);
			REG_FC_X:   prdata = DATA_W'(fc_x_q);
			REG_FC_Y:   prdata = DATA_W'(fc_y_q);
			REG_EXTENT: prdata = DATA_W'(extent_q);
			default:    prdata = '0;
		endcase
	end

	// Whole pipeline advances unless the skid entry is occupied
	assign en          = !sv_q;
	assign point_ready = en;

	assign xcfg.rot_x = rot_x_q;
	assign xcfg.rot_y = rot_y_q;
	assign xcfg.rot_z = rot_z_q;
	assign xcfg.trans = trans_q;

	ppp_transform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (point_valid),
		.point     (point),
		.cfg       (xcfg),
		.out_valid (tv),
		.cam       (cam)
	);

	// Multiply by focal lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= tv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s4 <= $signed({1'b0, fc_x_q[FC_W-1:0]}) * cam.x;
			num_y_s4 <= $signed({1'b0, fc_y_q[FC_W-1:0]}) * cam.y;
			den_s4   <= cam.z;
			zpos_s4  <= cam.zpos;
		end
	end

	// Floor division of a negative numerator: divide ~n, then invert the quotient
	assign mag_x = num_x_s4[NUM_W-1] ? DIV_W'(~num_x_s4) : DIV_W'(num_x_s4);
	assign mag_y = num_y_s4[NUM_W-1] ? DIV_W'(~num_y_s4) : DIV_W'(num_y_s4);

	ppp_divider #(
		.SIDE_W (3)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num_a     (mag_x),
		.num_b     (mag_y),
		.den       (den_s4),
		.side_in   ({zpos_s4, num_x_s4[NUM_W-1], num_y_s4[NUM_W-1]}),
		.out_valid (dv),
		.quo_a     (qx),
		.quo_b     (qy),
		.side_out  (dside)
	);

	// Restore sign and add principal point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= dv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zpos_s6    <= dside[2];
			u_s6       <= (dside[1] ? ~{2'b00, qx} : {2'b00, qx})
				+ U_W'(fc_x_q[2*FC_W-1:FC_W]);
			v_coord_s6 <= (dside[0] ? ~{2'b00, qy} : {2'b00, qy})
				+ U_W'(fc_y_q[2*FC_W-1:FC_W]);
		end
	end

	// Bounds check, zero invalid pixels, clamp wide coordinates
	assign wlim   = LIM_W'(extent_q[EXT_W-1:0]) << PIXEL_FRAC_BITS;
	assign hlim   = LIM_W'(extent_q[2*EXT_W-1:EXT_W]) << PIXEL_FRAC_BITS;
	assign in_img = zpos_s6 && !u_s6[U_W-1] && !v_coord_s6[U_W-1]
		&& (u_s6 <= $signed(U_W'(wlim))) && (v_coord_s6 <= $signed(U_W'(hlim)));

	always_comb begin
		item.pixel_valid = in_img;
		item.pixel_u     = '0;
		item.pixel_v     = '0;
		if (in_img) begin
			item.pixel_u = (u_s6[U_W-2:PIX_W] != '0) ? {PIX_W{1'b1}} : u_s6[PIX_W-1:0];
			item.pixel_v = (v_coord_s6[U_W-2:PIX_W] != '0) ? {PIX_W{1'b1}}
				: v_coord_s6[PIX_W-1:0];
		end
	end

	// Output register with one skid entry
	assign push = en & v_s6;
	assign pop  = ov_q & result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (pop)
				sv_q <= 1'b0;
		end else if (push) begin
			if (ov_q && !pop)
				sv_q <= 1'b1;
			ov_q <= 1'b1;
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (ov_q && !pop)
				skid_q <= item;
			else
				out_q <= item;
		end
	end

	assign result_valid = ov_q;
	assign result       = out_q;

	// Invalid pixels carry zero coordinates
	a_zero_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.pixel_valid |-> result.pixel_u == '0 && result.pixel_v == '0)
		else $error("invalid pixel with nonzero coordinates");

	// Skid entry only holds an item behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid entry full while output empty");

	// A full skid entry drains into the output when the output is taken
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q && result_ready |=> result_valid && !sv_q)
		else $error("skid entry did not drain");

endmodule
